### hw/rtl/mrtm_pkg.sv
package mrtm_pkg;

    localparam int COUNT_BITS = 16;
    localparam int GAIN_BITS  = 3;
    localparam int DIV_BITS   = 11;
    localparam int NUM_BITS   = 25;
    // quotient never reaches 2**18 because the smallest nonzero divisor exceeds 2**7
    localparam int Q_BITS     = 18;
    localparam int OUT_BITS   = 19;
    localparam int NUM_CELLS  = Q_BITS;
    localparam int N_LANES    = 3;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    localparam logic [9:0] SCALE_MILLI = 10'd1000;

    localparam logic [0:0] CFG_GAIN = 1'b0;
    localparam logic [0:0] CFG_SAT  = 1'b1;

    localparam logic [GAIN_BITS-1:0]  GAIN_RESET = 3'd1;
    localparam logic [COUNT_BITS-1:0] SAT_RESET  = 16'hF000;

    localparam logic [DIV_BITS-1:0] PER_GAUSS_XY [8] = '{
        11'd0, 11'd1100, 11'd855, 11'd670, 11'd450, 11'd400, 11'd330, 11'd230
    };
    localparam logic [DIV_BITS-1:0] PER_GAUSS_Z [8] = '{
        11'd0, 11'd980, 11'd760, 11'd600, 11'd400, 11'd355, 11'd295, 11'd205
    };

    typedef logic [N_LANES-1:0][DIV_BITS-1:0] t_divisors;

    typedef struct packed {
        logic [DIV_BITS-1:0] rem;
        logic [Q_BITS-1:0]   quo;
        logic                neg;
    } t_lane;

    typedef struct packed {
        t_lane [N_LANES-1:0] lane;
        logic                sat;
        logic                zero;
    } t_stage;

endpackage

### hw/rtl/mrtm_front.sv
module mrtm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_x_high,
    input  logic [7:0]                          i_x_low,
    input  logic [7:0]                          i_z_high,
    input  logic [7:0]                          i_z_low,
    input  logic [7:0]                          i_y_high,
    input  logic [7:0]                          i_y_low,
    input  logic [mrtm_pkg::GAIN_BITS-1:0]      i_gain,
    input  logic [mrtm_pkg::COUNT_BITS-1:0]     i_sat,
    input  mrtm_pkg::t_divisors                 i_divisor,
    output logic                                o_valid,
    input  logic                                i_ready,
    output mrtm_pkg::t_stage                    o_data
);

    logic [mrtm_pkg::COUNT_BITS-1:0] w_bits [mrtm_pkg::N_LANES];
    logic [mrtm_pkg::COUNT_BITS-1:0] w_mag  [mrtm_pkg::N_LANES];
    logic [mrtm_pkg::NUM_BITS-1:0]   w_num  [mrtm_pkg::N_LANES];
    mrtm_pkg::t_stage                n_data;
    mrtm_pkg::t_stage                r_data;
    logic                            r_valid;

    assign w_bits[mrtm_pkg::LANE_X] = {i_x_high, i_x_low};
    assign w_bits[mrtm_pkg::LANE_Y] = {i_y_high, i_y_low};
    assign w_bits[mrtm_pkg::LANE_Z] = {i_z_high, i_z_low};

    always_comb begin
        for (int k = 0; k < mrtm_pkg::N_LANES; k++) begin
            w_mag[k] = w_bits[k][mrtm_pkg::COUNT_BITS-1] ? (~w_bits[k] + 1'b1) : w_bits[k];
            // rounding offset is half the divisor, applied to the magnitude
            w_num[k] = mrtm_pkg::NUM_BITS'(w_mag[k]) * mrtm_pkg::NUM_BITS'(mrtm_pkg::SCALE_MILLI)
                     + mrtm_pkg::NUM_BITS'(i_divisor[k] >> 1);
            n_data.lane[k].neg = w_bits[k][mrtm_pkg::COUNT_BITS-1];
            n_data.lane[k].rem =
                mrtm_pkg::DIV_BITS'(w_num[k][mrtm_pkg::NUM_BITS-1:mrtm_pkg::Q_BITS]);
            n_data.lane[k].quo = w_num[k][mrtm_pkg::Q_BITS-1:0];
        end
        n_data.sat  = (w_bits[mrtm_pkg::LANE_X] == i_sat) || (w_bits[mrtm_pkg::LANE_Y] == i_sat)
                   || (w_bits[mrtm_pkg::LANE_Z] == i_sat);
        n_data.zero = (i_gain == '0);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/mrtm_cell.sv
module mrtm_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mrtm_pkg::t_stage     i_data,
    input  mrtm_pkg::t_divisors  i_divisor,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mrtm_pkg::t_stage     o_data
);

    logic [mrtm_pkg::DIV_BITS:0] w_trial [mrtm_pkg::N_LANES];
    logic [mrtm_pkg::DIV_BITS:0] w_diff  [mrtm_pkg::N_LANES];
    logic                        w_ge    [mrtm_pkg::N_LANES];
    mrtm_pkg::t_stage            n_data;
    mrtm_pkg::t_stage            r_data;
    logic                        r_valid;

    // one restoring division step per lane: shift in the next dividend bit, try subtract
    always_comb begin
        n_data = i_data;
        for (int k = 0; k < mrtm_pkg::N_LANES; k++) begin
            w_trial[k] = {i_data.lane[k].rem, i_data.lane[k].quo[mrtm_pkg::Q_BITS-1]};
            w_diff[k]  = w_trial[k] - {1'b0, i_divisor[k]};
            w_ge[k]    = (w_trial[k] >= {1'b0, i_divisor[k]});
            n_data.lane[k].rem = w_ge[k] ? w_diff[k][mrtm_pkg::DIV_BITS-1:0]
                                         : w_trial[k][mrtm_pkg::DIV_BITS-1:0];
            n_data.lane[k].quo = {i_data.lane[k].quo[mrtm_pkg::Q_BITS-2:0], w_ge[k]};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/magnetometer_raw_to_milligauss.sv
// Converts one six-byte magnetometer frame (X, Z, Y, big-endian per axis) to milligauss on
// all three axes, rounded half away from zero, with saturation and zero-gain flags. One frame
// is taken per clock unless output back-pressure has filled the pipeline, which is one input
// stage that forms count*1000 plus the rounding offset, then a chain of 18 restoring-division
// cells, each producing one quotient bit for all three axes. Stages advance independently, so
// bubbles close up under output stall. The gain and saturation registers are written through
// the config channel, which is always ready; write them only while no frame is in flight. Gain
// code 0 yields zero outputs with the zero-gain flag set.
module magnetometer_raw_to_milligauss (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [7:0]                               i_x_high,
    input  logic [7:0]                               i_x_low,
    input  logic [7:0]                               i_z_high,
    input  logic [7:0]                               i_z_low,
    input  logic [7:0]                               i_y_high,
    input  logic [7:0]                               i_y_low,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [mrtm_pkg::OUT_BITS-1:0]     o_x_milligauss,
    output logic signed [mrtm_pkg::OUT_BITS-1:0]     o_y_milligauss,
    output logic signed [mrtm_pkg::OUT_BITS-1:0]     o_z_milligauss,
    output logic                                     o_saturated_flag,
    output logic                                     o_zero_gain_flag,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [0:0]                               i_cfg_index,
    input  logic [mrtm_pkg::COUNT_BITS-1:0]          i_cfg_data
);

    logic [mrtm_pkg::GAIN_BITS-1:0]  r_gain;
    logic [mrtm_pkg::COUNT_BITS-1:0] r_sat;
    mrtm_pkg::t_divisors             w_divisor;

    logic             w_valid [mrtm_pkg::NUM_CELLS+1];
    logic             w_ready [mrtm_pkg::NUM_CELLS+1];
    mrtm_pkg::t_stage w_data  [mrtm_pkg::NUM_CELLS+1];

    logic signed [mrtm_pkg::OUT_BITS-1:0] w_mg [mrtm_pkg::N_LANES];
    logic [mrtm_pkg::OUT_BITS-1:0]        w_mag [mrtm_pkg::N_LANES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= mrtm_pkg::GAIN_RESET;
            r_sat  <= mrtm_pkg::SAT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mrtm_pkg::CFG_GAIN: r_gain <= i_cfg_data[mrtm_pkg::GAIN_BITS-1:0];
                mrtm_pkg::CFG_SAT:  r_sat  <= i_cfg_data;
            endcase
        end
    end

    assign w_divisor[mrtm_pkg::LANE_X] = mrtm_pkg::PER_GAUSS_XY[r_gain];
    assign w_divisor[mrtm_pkg::LANE_Y] = mrtm_pkg::PER_GAUSS_XY[r_gain];
    assign w_divisor[mrtm_pkg::LANE_Z] = mrtm_pkg::PER_GAUSS_Z[r_gain];

    mrtm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_x_high  (i_x_high),
        .i_x_low   (i_x_low),
        .i_z_high  (i_z_high),
        .i_z_low   (i_z_low),
        .i_y_high  (i_y_high),
        .i_y_low   (i_y_low),
        .i_gain    (r_gain),
        .i_sat     (r_sat),
        .i_divisor (w_divisor),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_data    (w_data[0])
    );

    for (genvar g = 0; g < mrtm_pkg::NUM_CELLS; g++) begin : g_cell
        mrtm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_valid[g]),
            .o_ready   (w_ready[g]),
            .i_data    (w_data[g]),
            .i_divisor (w_divisor),
            .o_valid   (w_valid[g+1]),
            .i_ready   (w_ready[g+1]),
            .o_data    (w_data[g+1])
        );
    end

    assign w_ready[mrtm_pkg::NUM_CELLS] = i_out_ready;
    assign o_out_valid = w_valid[mrtm_pkg::NUM_CELLS];

    // restore the sign, zero the three outputs when the divisor is zero
    always_comb begin
        for (int k = 0; k < mrtm_pkg::N_LANES; k++) begin
            w_mag[k] = {1'b0, w_data[mrtm_pkg::NUM_CELLS].lane[k].quo};
            if (w_data[mrtm_pkg::NUM_CELLS].zero) begin
                w_mg[k] = '0;
            end else if (w_data[mrtm_pkg::NUM_CELLS].lane[k].neg) begin
                w_mg[k] = -$signed(w_mag[k]);
            end else begin
                w_mg[k] = $signed(w_mag[k]);
            end
        end
    end

    assign o_x_milligauss   = w_mg[mrtm_pkg::LANE_X];
    assign o_y_milligauss   = w_mg[mrtm_pkg::LANE_Y];
    assign o_z_milligauss   = w_mg[mrtm_pkg::LANE_Z];
    assign o_saturated_flag = w_data[mrtm_pkg::NUM_CELLS].sat;
    assign o_zero_gain_flag = w_data[mrtm_pkg::NUM_CELLS].zero;

endmodule

### dv/magnetometer_raw_to_milligauss_tb.sv
module magnetometer_raw_to_milligauss_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY       = 19;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_FRAMES  = 250;

    // counts per gauss by gain code
    localparam int unsigned XY_PER_GAUSS [8] = '{0, 1100, 855, 670, 450, 400, 330, 230};
    localparam int unsigned Z_PER_GAUSS  [8] = '{0, 980, 760, 600, 400, 355, 295, 205};

    typedef struct packed {
        logic signed [mrtm_pkg::OUT_BITS-1:0] x_mg;
        logic signed [mrtm_pkg::OUT_BITS-1:0] y_mg;
        logic signed [mrtm_pkg::OUT_BITS-1:0] z_mg;
        logic                                 saturated;
        logic                                 zero_gain;
    } t_reading;

    typedef enum logic [1:0] {ROW_FRAME, ROW_SET_GAIN, ROW_SET_SAT} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [15:0] reg_value;
        logic [15:0] x_raw;
        logic [15:0] z_raw;
        logic [15:0] y_raw;
        bit          typed;
        t_reading    want;
    } t_step;

    localparam t_reading NO_READING = '0;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic [7:0]                           i_x_high;
    logic [7:0]                           i_x_low;
    logic [7:0]                           i_z_high;
    logic [7:0]                           i_z_low;
    logic [7:0]                           i_y_high;
    logic [7:0]                           i_y_low;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic signed [mrtm_pkg::OUT_BITS-1:0] o_x_milligauss;
    logic signed [mrtm_pkg::OUT_BITS-1:0] o_y_milligauss;
    logic signed [mrtm_pkg::OUT_BITS-1:0] o_z_milligauss;
    logic                                 o_saturated_flag;
    logic                                 o_zero_gain_flag;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [0:0]                           i_cfg_index;
    logic [mrtm_pkg::COUNT_BITS-1:0]      i_cfg_data;

    magnetometer_raw_to_milligauss dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_x_high         (i_x_high),
        .i_x_low          (i_x_low),
        .i_z_high         (i_z_high),
        .i_z_low          (i_z_low),
        .i_y_high         (i_y_high),
        .i_y_low          (i_y_low),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_x_milligauss   (o_x_milligauss),
        .o_y_milligauss   (o_y_milligauss),
        .o_z_milligauss   (o_z_milligauss),
        .o_saturated_flag (o_saturated_flag),
        .o_zero_gain_flag (o_zero_gain_flag),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    logic [mrtm_pkg::GAIN_BITS-1:0]  gain_setting;
    logic [mrtm_pkg::COUNT_BITS-1:0] sat_setting;
    t_reading                        pending_readings[$];
    int                              mismatch_count;
    bit                              idling_on;

    t_step directed_steps[] = '{
        '{ROW_FRAME,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
          {19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b0}},
        '{ROW_FRAME,    16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'hF000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h0000, 16'hF000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h0000, 16'h0000, 16'hF000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h55AA, 16'hAA55, 16'h00FF, 1'b0, NO_READING},
        '{ROW_SET_GAIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h7FFF, 16'h8000, 16'h1234, 1'b1,
          {19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b1}},
        '{ROW_FRAME,    16'h0000, 16'hF000, 16'h0000, 16'h0000, 1'b1,
          {19'sd0, 19'sd0, 19'sd0, 1'b1, 1'b1}},
        '{ROW_SET_GAIN, 16'h0007, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, NO_READING},
        '{ROW_SET_SAT,  16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_SET_SAT,  16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, NO_READING},
        '{ROW_SET_SAT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
          {19'sd0, 19'sd0, 19'sd0, 1'b1, 1'b0}},
        '{ROW_SET_GAIN, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h0203, 16'hFDFC, 16'h4000, 1'b0, NO_READING},
        '{ROW_SET_GAIN, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'hC000, 16'h3FFF, 16'h0335, 1'b0, NO_READING},
        '{ROW_SET_GAIN, 16'h0004, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h0001, 16'hFFFF, 16'h7F00, 1'b0, NO_READING},
        '{ROW_SET_GAIN, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h8001, 16'h00C8, 16'hFF38, 1'b0, NO_READING},
        '{ROW_SET_GAIN, 16'h0006, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_READING},
        '{ROW_FRAME,    16'h0000, 16'h1111, 16'hEEEE, 16'h0A5F, 1'b0, NO_READING}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // count*1000 over counts per gauss, half away from zero
    function automatic logic signed [mrtm_pkg::OUT_BITS-1:0] to_milligauss(
        logic [15:0] raw, int unsigned per_gauss);
        longint num;
        longint half;
        longint divisor;
        longint quo;
        if (per_gauss == 0) begin
            return '0;
        end
        divisor = longint'(per_gauss);
        num     = longint'($signed(raw)) * 1000;
        half    = divisor / 2;
        quo     = (num >= 0) ? (num + half) / divisor : (num - half) / divisor;
        return quo[mrtm_pkg::OUT_BITS-1:0];
    endfunction

    function automatic t_reading predict_reading(logic [15:0] x_raw, logic [15:0] z_raw,
                                                 logic [15:0] y_raw);
        t_reading r;
        r.x_mg      = to_milligauss(x_raw, XY_PER_GAUSS[gain_setting]);
        r.y_mg      = to_milligauss(y_raw, XY_PER_GAUSS[gain_setting]);
        r.z_mg      = to_milligauss(z_raw, Z_PER_GAUSS[gain_setting]);
        r.saturated = (x_raw == sat_setting) || (y_raw == sat_setting)
                   || (z_raw == sat_setting);
        r.zero_gain = (gain_setting == 0);
        return r;
    endfunction

    task automatic send_frame(logic [15:0] x_raw, logic [15:0] z_raw, logic [15:0] y_raw,
                              bit typed, t_reading want);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        {i_x_high, i_x_low} <= x_raw;
        {i_z_high, i_z_low} <= z_raw;
        {i_y_high, i_y_low} <= y_raw;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readings.push_back(typed ? want : predict_reading(x_raw, z_raw, y_raw));
    endtask

    // let every frame in flight drain before touching the registers
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == mrtm_pkg::CFG_GAIN) begin
            gain_setting = value[mrtm_pkg::GAIN_BITS-1:0];
        end else begin
            sat_setting = value;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_raw();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return (sat_setting);
            3: return 16'(($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF);
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver back-pressure in bursts
    initial begin
        int span;
        logic level;
        i_out_ready = 1'b0;
        forever begin
            if (idling_on && $urandom_range(0, 4) == 0) begin
                span  = $urandom_range(1, 17);
                level = 1'b0;
            end else begin
                span  = $urandom_range(1, 20);
                level = 1'b1;
            end
            repeat (span) begin
                @(negedge i_clk);
                i_out_ready <= level;
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: result transfer with nothing expected: x %0d y %0d z %0d",
                         $time, o_x_milligauss, o_y_milligauss, o_z_milligauss);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (o_x_milligauss !== want.x_mg) begin
                    $display("%0t: x_milligauss expected %0d actual %0d",
                             $time, want.x_mg, o_x_milligauss);
                    mismatch_count++;
                end
                if (o_y_milligauss !== want.y_mg) begin
                    $display("%0t: y_milligauss expected %0d actual %0d",
                             $time, want.y_mg, o_y_milligauss);
                    mismatch_count++;
                end
                if (o_z_milligauss !== want.z_mg) begin
                    $display("%0t: z_milligauss expected %0d actual %0d",
                             $time, want.z_mg, o_z_milligauss);
                    mismatch_count++;
                end
                if (o_saturated_flag !== want.saturated) begin
                    $display("%0t: saturated_flag expected %0b actual %0b",
                             $time, want.saturated, o_saturated_flag);
                    mismatch_count++;
                end
                if (o_zero_gain_flag !== want.zero_gain) begin
                    $display("%0t: zero_gain_flag expected %0b actual %0b",
                             $time, want.zero_gain, o_zero_gain_flag);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [15:0] gain_value;
        logic [15:0] sat_value;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_x_high       = '0;
        i_x_low        = '0;
        i_z_high       = '0;
        i_z_low        = '0;
        i_y_high       = '0;
        i_y_low        = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = mrtm_pkg::CFG_GAIN;
        i_cfg_data     = '0;
        gain_setting   = mrtm_pkg::GAIN_BITS'(1);
        sat_setting    = 16'hF000;
        mismatch_count = 0;
        idling_on      = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            case (directed_steps[i].kind)
                ROW_FRAME: begin
                    send_frame(directed_steps[i].x_raw, directed_steps[i].z_raw,
                               directed_steps[i].y_raw, directed_steps[i].typed,
                               directed_steps[i].want);
                end
                ROW_SET_GAIN: begin
                    drain();
                    write_reg(mrtm_pkg::CFG_GAIN, directed_steps[i].reg_value);
                end
                ROW_SET_SAT: begin
                    drain();
                    write_reg(mrtm_pkg::CFG_SAT, directed_steps[i].reg_value);
                end
                default: ;
            endcase
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: gain_value = 16'd0;
                1: gain_value = 16'd7;
                default: gain_value = 16'($urandom_range(0, 7));
            endcase
            case (phase)
                2: sat_value = 16'h8000;
                3: sat_value = 16'h7FFF;
                default: sat_value = 16'($urandom);
            endcase
            drain();
            write_reg(mrtm_pkg::CFG_GAIN, gain_value);
            write_reg(mrtm_pkg::CFG_SAT, sat_value);
            // the last stretch runs at full rate on both sides
            if (phase == RANDOM_PHASES - 1) begin
                idling_on = 1'b0;
            end
            repeat (PHASE_FRAMES) begin
                send_frame(random_raw(), random_raw(), random_raw(), 1'b0, NO_READING);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
